### rtl/fpl2_pkg.sv
// ----------------------------------------------------------------------------
// fpl2_pkg
// Shared types and constants of the fixed-point base-2 logarithm core.
// ----------------------------------------------------------------------------
package fpl2_pkg;

  localparam int VALUE_W = 32;
  localparam int RES_W   = 21;
  localparam int LEAD_W  = 5;
  // integer part of the log: leading-one position minus fraction bits
  localparam int INT_W   = 7;

  localparam logic signed [RES_W-1:0] RES_MAX = 21'sh0FFFFF;
  localparam logic signed [RES_W-1:0] RES_MIN = 21'sh100000;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [RES_W-1:0]   log_t;

  typedef struct packed {
    logic valid;
    logic domain_error;
  } fpl2_ctl_t;

endpackage

### rtl/fpl2_if.sv
// ----------------------------------------------------------------------------
// fpl2_if
// Valid/ready channels carrying operand and result beats.
// ----------------------------------------------------------------------------
interface fpl2_operand_if;
  import fpl2_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface fpl2_result_if;
  import fpl2_pkg::*;

  logic valid;
  logic ready;
  log_t log_result;
  logic domain_error;

  modport source (output valid, output log_result, output domain_error, input ready);
  modport sink (input valid, input log_result, input domain_error, output ready);
endinterface

### rtl/fpl2_square_stage.sv
// ----------------------------------------------------------------------------
// fpl2_square_stage
// One squaring round: rounded square, halve on overflow, decide one bit.
// ----------------------------------------------------------------------------
module fpl2_square_stage #(
  parameter int FRAC_BITS = 16,
  parameter int STEP      = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  fpl2_pkg::fpl2_ctl_t              ctl_in,
  input  logic [FRAC_BITS:0]               z_in,
  input  logic signed [fpl2_pkg::INT_W-1:0] int_in,
  input  logic [FRAC_BITS-1:0]             frac_in,
  output fpl2_pkg::fpl2_ctl_t              ctl,
  output logic [FRAC_BITS:0]               z,
  output logic signed [fpl2_pkg::INT_W-1:0] int_part,
  output logic [FRAC_BITS-1:0]             frac
);
  import fpl2_pkg::*;

  localparam int ZW = FRAC_BITS + 1;
  localparam int PW = 2 * ZW;
  localparam logic [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);

  logic [PW-1:0]          prod;
  logic [FRAC_BITS+1:0]   sq;
  logic [FRAC_BITS:0]     z_next;
  logic [FRAC_BITS-1:0]   frac_next;

  always_comb begin
    prod = PW'(z_in) * PW'(z_in) + RND;
    sq   = prod[FRAC_BITS +: FRAC_BITS + 2];
    frac_next = frac_in;
    frac_next[FRAC_BITS-1-STEP] = sq[FRAC_BITS+1];
    if (sq[FRAC_BITS+1]) begin
      z_next = sq[FRAC_BITS+1:1];
    end else begin
      z_next = sq[FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z        <= z_next;
      int_part <= int_in;
      frac     <= frac_next;
    end
  end

endmodule

### rtl/fixed_point_log2_core.sv
// ----------------------------------------------------------------------------
// fixed_point_log2_core
// Pipelined base-2 logarithm of a signed fixed-point operand.
// ----------------------------------------------------------------------------
// Usage:
//   operand: valid/ready beat carrying a signed fixed-point value with
//            FRAC_BITS fraction bits; only the low WORD_BITS bits count.
//   result : one beat per operand, in order: log_result (same format,
//            saturated to 21 bits) and domain_error (operand <= 0, log 0).
//   Stages: leading-one detect, normalise, one stage per squaring round,
//            saturation/output register.
//   Throughput: one beat per cycle unless stalled; each squaring round has its own
//            multiplier, so nothing is shared between beats.
//   Stall: when result is held off with its output register full, the whole
//            pipeline freezes and operand.ready drops; no beat is lost or
//            repeated. Bubbles are carried as cleared valid bits.
//   Reset: rst (synchronous) clears every valid bit; the pipeline is empty
//            and ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module fixed_point_log2_core #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input logic           clk,
  input logic           rst,
  fpl2_operand_if.sink  operand,
  fpl2_result_if.source result
);
  import fpl2_pkg::*;

  localparam int ZW = FRAC_BITS + 1;
  localparam int YW = INT_W + FRAC_BITS;
  localparam int CW = (YW > RES_W) ? YW : RES_W;

  logic en;

  // leading-one stage
  logic [WORD_BITS-1:0] v_word;
  logic                 dom_next;
  logic [LEAD_W-1:0]    lead_next;
  fpl2_ctl_t            a_ctl;
  logic [WORD_BITS-1:0] a_v;
  logic [LEAD_W-1:0]    a_lead;

  // normalise stage
  logic [WORD_BITS+FRAC_BITS-1:0] norm;
  fpl2_ctl_t                      b_ctl;
  logic [FRAC_BITS:0]             b_z;
  logic signed [INT_W-1:0]        b_int;

  // squaring chain
  fpl2_ctl_t               s_ctl  [0:FRAC_BITS];
  logic [ZW-1:0]           s_z    [0:FRAC_BITS];
  logic signed [INT_W-1:0] s_int  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]    s_frac [0:FRAC_BITS];

  // output stage
  logic signed [YW-1:0] y;
  logic signed [CW-1:0] y_ext;
  log_t                 sat;
  logic                 out_valid;
  log_t                 out_log;
  logic                 out_dom;

  assign en            = !out_valid || result.ready;
  assign operand.ready = en;

  always_comb begin
    v_word    = operand.value[WORD_BITS-1:0];
    dom_next  = (v_word == '0) || v_word[WORD_BITS-1];
    lead_next = '0;
    for (int k = 0; k < WORD_BITS - 1; k++) begin
      if (v_word[k]) begin
        lead_next = LEAD_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
      b_ctl <= '0;
    end else if (en) begin
      a_ctl <= '{valid: operand.valid, domain_error: dom_next};
      b_ctl <= a_ctl;
    end
  end

  assign norm = {a_v, {FRAC_BITS{1'b0}}} >> a_lead;

  always_ff @(posedge clk) begin
    if (en) begin
      a_v    <= v_word;
      a_lead <= lead_next;
      b_z    <= norm[ZW-1:0];
      b_int  <= $signed({2'b00, a_lead}) - INT_W'(FRAC_BITS);
    end
  end

  assign s_ctl[0]  = b_ctl;
  assign s_z[0]    = b_z;
  assign s_int[0]  = b_int;
  assign s_frac[0] = '0;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_round
    fpl2_square_stage #(
      .FRAC_BITS (FRAC_BITS),
      .STEP      (i)
    ) u_round (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (s_ctl[i]),
      .z_in     (s_z[i]),
      .int_in   (s_int[i]),
      .frac_in  (s_frac[i]),
      .ctl      (s_ctl[i+1]),
      .z        (s_z[i+1]),
      .int_part (s_int[i+1]),
      .frac     (s_frac[i+1])
    );
  end

  always_comb begin
    y     = $signed({s_int[FRAC_BITS], s_frac[FRAC_BITS]});
    y_ext = CW'(y);
    if (y_ext > CW'(RES_MAX)) begin
      sat = RES_MAX;
    end else if (y_ext < CW'(RES_MIN)) begin
      sat = RES_MIN;
    end else begin
      sat = y_ext[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_ctl[FRAC_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dom <= s_ctl[FRAC_BITS].domain_error;
      out_log <= s_ctl[FRAC_BITS].domain_error ? '0 : sat;
    end
  end

  assign result.valid        = out_valid;
  assign result.log_result   = out_log;
  assign result.domain_error = out_dom;

endmodule
